[hw/rtl/mec_pkg.sv]
// ============================================================================
// mec_pkg
// Shared widths, register indexes and controller/datapath link types for the
// Mandelbrot escape counter.
// ============================================================================
package mec_pkg;

   localparam int POS_W      = 10;   // pixel column / row
   localparam int DIM_W      = 11;   // image width / height register
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int DIV_STEPS  = 4;    // quotient bits per divider cycle

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 11'd125;

   typedef struct packed {
      logic div_start;
      logic load;
      logic mul;
      logic update;
   } mec_cmd_type;

   typedef struct packed {
      logic div_done;
      logic escape;
   } mec_sts_type;

endpackage

[hw/rtl/mec_div.sv]
// ============================================================================
// mec_div
// Radix-16 restoring divider: |2*pos - dim| * 2^FRAC_BITS / dim, truncated,
// with the sign of 2*pos - dim reported on the side.
// ============================================================================
module mec_div #(
   parameter int FRAC_BITS = 28
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mec_pkg::POS_W-1:0]   pos,
   input  logic [mec_pkg::DIM_W-1:0]   dim,
   output logic                        done,
   output logic                        negative,
   output logic [((mec_pkg::POS_W + 1 + FRAC_BITS + mec_pkg::DIV_STEPS - 1)
                  / mec_pkg::DIV_STEPS) * mec_pkg::DIV_STEPS - 1:0] quotient
);

   localparam int AW    = mec_pkg::POS_W + 1;
   localparam int NQ    = AW + FRAC_BITS;
   localparam int S     = mec_pkg::DIV_STEPS;
   localparam int NB    = ((NQ + S - 1) / S) * S;
   localparam int NCYC  = NB / S;
   localparam int CNT_W = $clog2(NCYC + 1);
   localparam int DW    = mec_pkg::DIM_W;

   logic [NB-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dim_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             neg_ff;
   logic [AW:0]      diff;
   logic [AW-1:0]    mag;

   assign diff = (AW + 1)'({pos, 1'b0}) - (AW + 1)'(dim);
   assign mag  = diff[AW] ? AW'(-diff) : diff[AW-1:0];

   always_comb begin
      logic [DW-1:0] r;
      logic [NB-1:0] q;
      logic [DW:0]   r2;
      logic          ge;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < S; i++) begin
         r2 = {r, q[NB-1]};
         ge = (r2 >= {1'b0, dim_ff});
         if (ge) begin
            r2 = r2 - {1'b0, dim_ff};
         end
         r = r2[DW-1:0];
         q = {q[NB-2:0], ge};
      end
      rem_in = r;
      quo_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(NCYC);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= NB'({mag, {FRAC_BITS{1'b0}}});
         rem_ff <= '0;
         dim_ff <= dim;
         neg_ff <= diff[AW];
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = (cnt_ff == '0);
   assign negative = neg_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/mec_dp.sv]
// ============================================================================
// mec_dp
// Datapath: image size registers, coordinate dividers and the shared complex
// square-and-add unit with its escape test.
// ============================================================================
module mec_dp #(
   parameter int FRAC_BITS = 28,
   parameter int MAX_DIM   = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [mec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mec_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic [mec_pkg::POS_W-1:0]         pixel_column,
   input  logic [mec_pkg::POS_W-1:0]         pixel_row,
   input  mec_pkg::mec_cmd_type              cmd,
   output mec_pkg::mec_sts_type              sts
);

   localparam int DW  = mec_pkg::DIM_W;
   localparam int QW  = FRAC_BITS + 4;
   localparam int PW  = 2 * QW;
   localparam int SW  = PW - FRAC_BITS + 2;
   localparam int S   = mec_pkg::DIV_STEPS;
   localparam int NB  = ((mec_pkg::POS_W + 1 + FRAC_BITS + S - 1) / S) * S;
   localparam int CVW = NB + 2;
   localparam int MW  = (SW > CVW) ? SW : CVW;

   localparam logic [DW+1:0] MAX_DIM_C = (DW + 2)'(MAX_DIM);
   localparam logic signed [MW-1:0] QMAX_S = {{(MW-QW+1){1'b0}}, {(QW-1){1'b1}}};
   localparam logic signed [MW-1:0] QMIN_S = {{(MW-QW+1){1'b1}}, {(QW-1){1'b0}}};
   localparam logic signed [SW-1:0] FOUR_S = SW'(4) << FRAC_BITS;
   localparam logic signed [CVW-1:0] HALF_S = CVW'(1) << (FRAC_BITS - 1);

   function automatic logic signed [QW-1:0] sat_q(input logic signed [MW-1:0] v);
      logic signed [QW-1:0] r;
      if (v > QMAX_S) begin
         r = {1'b0, {(QW-1){1'b1}}};
      end else if (v < QMIN_S) begin
         r = {1'b1, {(QW-1){1'b0}}};
      end else begin
         r = v[QW-1:0];
      end
      return r;
   endfunction

   logic [DW-1:0] img_w_ff, img_h_ff;
   logic [DW-1:0] eff_w, eff_h;

   logic          div_x_done, div_y_done, neg_x, neg_y;
   logic [NB-1:0] quo_x, quo_y;

   logic signed [QW-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [QW-1:0] re_ff, im_ff, re_in, im_in;
   logic signed [PW-1:0] prr_ff, pii_ff, pri_ff;

   logic signed [CVW-1:0] vx, vy, cx;
   logic signed [SW-1:0]  rr, ii, ri, mag2, re_sum, im_sum;
   logic                  ri_fix;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= mec_pkg::IMAGE_DIM_RESET;
         img_h_ff <= mec_pkg::IMAGE_DIM_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == mec_pkg::CSR_IMAGE_WIDTH) begin
            img_w_ff <= csr_write_data;
         end
         if (csr_index == mec_pkg::CSR_IMAGE_HEIGHT) begin
            img_h_ff <= csr_write_data;
         end
      end
   end

   always_comb begin
      if (img_w_ff == '0) begin
         eff_w = DW'(1);
      end else if ({2'b00, img_w_ff} > MAX_DIM_C) begin
         eff_w = MAX_DIM_C[DW-1:0];
      end else begin
         eff_w = img_w_ff;
      end
      if (img_h_ff == '0) begin
         eff_h = DW'(1);
      end else if ({2'b00, img_h_ff} > MAX_DIM_C) begin
         eff_h = MAX_DIM_C[DW-1:0];
      end else begin
         eff_h = img_h_ff;
      end
   end

   mec_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .pos      (pixel_column),
      .dim      (eff_w),
      .done     (div_x_done),
      .negative (neg_x),
      .quotient (quo_x)
   );

   mec_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .pos      (pixel_row),
      .dim      (eff_h),
      .done     (div_y_done),
      .negative (neg_y),
      .quotient (quo_y)
   );

   // Coordinates
   assign vx   = neg_x ? -$signed({2'b00, quo_x}) : $signed({2'b00, quo_x});
   assign vy   = neg_y ? -$signed({2'b00, quo_y}) : $signed({2'b00, quo_y});
   assign cx   = vx - HALF_S;
   assign x_in = sat_q(MW'(cx));
   assign y_in = sat_q(MW'(vy));

   // Truncated products, update sums and escape test
   assign rr     = SW'($signed(prr_ff[PW-1:FRAC_BITS]));
   assign ii     = SW'($signed(pii_ff[PW-1:FRAC_BITS]));
   assign ri     = SW'($signed(pri_ff[PW-1:FRAC_BITS-1]));
   assign ri_fix = pri_ff[PW-1] & (|pri_ff[FRAC_BITS-2:0]);
   assign mag2   = rr + ii;
   assign re_sum = rr - ii + SW'(x_ff);
   assign im_sum = ri + SW'(y_ff) + SW'(ri_fix);
   assign re_in  = sat_q(MW'(re_sum));
   assign im_in  = sat_q(MW'(im_sum));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         re_ff <= '0;
         im_ff <= '0;
      end else if (cmd.update) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
      if (cmd.mul) begin
         prr_ff <= PW'(re_ff) * PW'(re_ff);
         pii_ff <= PW'(im_ff) * PW'(im_ff);
         pri_ff <= PW'(re_ff) * PW'(im_ff);
      end
   end

   assign sts.div_done = div_x_done & div_y_done;
   assign sts.escape   = (mag2 > FOUR_S);

endmodule

[hw/rtl/mec_ctrl.sv]
// ============================================================================
// mec_ctrl
// Controller: takes a pixel, sequences division, product and update steps,
// counts iterations and issues the result beat.
// ============================================================================
module mec_ctrl #(
   parameter int MAX_ITER = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   output logic                               rsp_strobe,
   output logic [$clog2(MAX_ITER + 1)-1:0]    rsp_escape_count,
   output mec_pkg::mec_cmd_type               cmd,
   input  mec_pkg::mec_sts_type               sts
);

   localparam int CW = $clog2(MAX_ITER + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_UPD
   } state_type;

   state_type       state_ff;
   logic            busy_ff;
   logic            strobe_ff;
   logic [CW-1:0]   iter_ff;
   logic [CW-1:0]   count_ff;

   always_comb begin
      cmd.div_start = (state_ff == ST_IDLE) & start;
      cmd.load      = (state_ff == ST_DIV) & sts.div_done;
      cmd.mul       = (state_ff == ST_MUL);
      cmd.update    = (state_ff == ST_UPD) & ~sts.escape;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         iter_ff   <= '0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_DIV;
                  busy_ff  <= 1'b1;
               end
            end
            ST_DIV: begin
               if (sts.div_done) begin
                  state_ff <= ST_MUL;
                  iter_ff  <= '0;
               end
            end
            ST_MUL: begin
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (sts.escape) begin
                  state_ff  <= ST_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
                  count_ff  <= iter_ff;
               end else if (iter_ff == CW'(MAX_ITER - 1)) begin
                  state_ff  <= ST_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
                  count_ff  <= CW'(MAX_ITER);
               end else begin
                  state_ff <= ST_MUL;
                  iter_ff  <= iter_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_escape_count = count_ff;

endmodule

[hw/rtl/mandelbrot_escape_counter.sv]
// ============================================================================
// mandelbrot_escape_counter
// Maps a pixel to a point c of the complex plane and counts the iterations
// of z = z^2 + c taken while |z|^2 stays at most four.
//
//   channel  ports                               beat taken when
//   -------  ----------------------------------  ----------------------------
//   request  start, req_pixel_column/_row, busy  start high, busy low
//   result   rsp_strobe, rsp_escape_count        rsp_strobe high (one cycle)
//   csr      csr_write_enable, csr_index, data   csr_write_enable high
//
// The coordinate divider retires four quotient bits a cycle; each iteration
// passes through the product register, then the update.
// One pixel at a time; busy drops in the cycle of the result beat, and a new
// start is taken in that same cycle. Reset clears control and sets both image
// sizes to 125. The result beat cannot be held off.
// ============================================================================
module mandelbrot_escape_counter #(
   parameter int MAX_ITER  = 16,
   parameter int MAX_DIM   = 1024,
   parameter int FRAC_BITS = 28
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [mec_pkg::POS_W-1:0]          req_pixel_column,
   input  logic [mec_pkg::POS_W-1:0]          req_pixel_row,
   output logic                               rsp_strobe,
   output logic [$clog2(MAX_ITER + 1)-1:0]    rsp_escape_count,
   input  logic                               csr_write_enable,
   input  logic [mec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mec_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   mec_pkg::mec_cmd_type cmd;
   mec_pkg::mec_sts_type sts;

   mec_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .rsp_strobe       (rsp_strobe),
      .rsp_escape_count (rsp_escape_count),
      .cmd              (cmd),
      .sts              (sts)
   );

   mec_dp #(.FRAC_BITS(FRAC_BITS), .MAX_DIM(MAX_DIM)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pixel_column     (req_pixel_column),
      .pixel_row        (req_pixel_row),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

[hw/rtl/mec_checker.sv]
// ============================================================================
// mec_checker
// Port-level checks of the escape counter's request/result sequencing.
// ============================================================================
module mec_checker #(
   parameter int MAX_ITER = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               rsp_strobe,
   input  logic [$clog2(MAX_ITER + 1)-1:0]    rsp_escape_count
);

   localparam int CW = $clog2(MAX_ITER + 1);

   // an accepted beat occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted beat");

   // busy drops only with the result beat
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result beat");

   // no result beat without a pixel in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result beat outside a pixel");

   // count never exceeds the iteration limit
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_escape_count <= CW'(MAX_ITER)))
      else $error("escape count out of range");

endmodule

bind mandelbrot_escape_counter mec_checker #(.MAX_ITER(MAX_ITER)) u_mec_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_escape_count (rsp_escape_count)
);
